// ----- hw/rtl/llwa_pkg.sv -----
`default_nettype none
package llwa_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int IDX_W       = $clog2(MAX_WORKERS);
    localparam int LOAD_W      = 32;
    localparam int JOB_W       = 16;
    localparam int NUMW_W      = 5;
    localparam int WIDX_OUT_W  = 4;
    localparam int ADDR_W      = 3;
    localparam int APB_W       = 32;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 56;

    // register index decoded from paddr[2]
    localparam logic REG_NUM_WORKERS = 1'b0;

    localparam logic [NUMW_W-1:0] NUMW_RESET = NUMW_W'(16);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // search wavefront handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              have;
        logic [LOAD_W-1:0] load;
        logic [IDX_W-1:0]  idx;
    } t_carry;

    // broadcast load update
    typedef struct packed {
        logic              clr;
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [LOAD_W-1:0] data;
    } t_wr;

endpackage
`default_nettype wire

// ----- hw/rtl/llwa_cell.sv -----
`default_nettype none
module llwa_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [llwa_pkg::IDX_W-1:0]   i_idx,
    input  wire                          i_active,
    input  llwa_pkg::t_carry             i_carry,
    input  llwa_pkg::t_wr                i_wr,
    output llwa_pkg::t_carry             o_carry
);

    logic [llwa_pkg::LOAD_W-1:0] r_load, n_load;
    llwa_pkg::t_carry            r_carry, n_carry;
    logic                        w_take;

    // strict less-than keeps the lowest index on a tie
    assign w_take = i_active && (!i_carry.have || (r_load < i_carry.load));

    always_comb begin
        n_load = r_load;
        if (i_wr.clr) begin
            n_load = '0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            n_load = i_wr.data;
        end
    end

    always_comb begin
        n_carry = i_carry;
        if (w_take) begin
            n_carry.have = 1'b1;
            n_carry.load = r_load;
            n_carry.idx  = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_carry <= '0;
        end else begin
            r_load  <= n_load;
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;

endmodule
`default_nettype wire

// ----- hw/rtl/least_loaded_worker_assign_top.sv -----
`default_nettype none
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: job_id, job_size; tuser: start_batch
// m_axis    out  m_axis_tvalid/tready      tdata: out_job_id, worker_index, worker_load
// apb       in   psel/penable/pwrite       paddr, pwdata -> num_workers; prdata readback
//
// Each item passes through an accept, a search that moves one cell per cycle
// along the worker chain, a step that takes the winner off the end of the
// chain, and a write-back.
// The chain holds one cell per worker.
// Synchronous active-low reset zeroes all loads and sets num_workers to 16.
// A result waits in the output register; a stalled m_axis holds the block in
// write-back, and s_axis_tready stays low until the item has been written back.
module least_loaded_worker_assign_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // [15:0] job_id, [31:16] job_size
    input  wire  [llwa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] start_batch
    input  wire                               s_axis_tuser,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] out_job_id, [19:16] worker_index, [51:20] worker_load, [55:52] zero
    output logic [llwa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [llwa_pkg::ADDR_W-1:0]       paddr,
    input  wire  [llwa_pkg::APB_W-1:0]        pwdata,
    output logic [llwa_pkg::APB_W-1:0]        prdata,
    output logic                              pready
);

    localparam int NW = llwa_pkg::MAX_WORKERS;

    llwa_pkg::t_state                   r_state, n_state;
    logic [llwa_pkg::NUMW_W-1:0]        r_num_workers;
    logic [llwa_pkg::JOB_W-1:0]         r_job_id, n_job_id;
    logic [llwa_pkg::JOB_W-1:0]         r_job_size, n_job_size;
    logic                               r_head_vld, n_head_vld;
    logic [llwa_pkg::IDX_W-1:0]         r_best_idx, n_best_idx;
    logic [llwa_pkg::LOAD_W-1:0]        r_best_load, n_best_load;
    logic                               r_out_vld, n_out_vld;
    logic [llwa_pkg::OUT_DATA_W-1:0]    r_out_data, n_out_data;

    llwa_pkg::t_carry                   w_carry [0:NW];
    llwa_pkg::t_wr                      w_wr;
    logic [NW-1:0]                      w_active;
    logic                               w_in_acc;
    logic                               w_finish;
    logic [llwa_pkg::LOAD_W:0]          w_sum;
    logic [llwa_pkg::LOAD_W-1:0]        w_new_load;
    logic [llwa_pkg::IDX_W+llwa_pkg::WIDX_OUT_W-1:0] w_idx_ext;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_workers <= llwa_pkg::NUMW_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == llwa_pkg::REG_NUM_WORKERS)) begin
            r_num_workers <= pwdata[llwa_pkg::NUMW_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == llwa_pkg::REG_NUM_WORKERS) begin
            prdata = llwa_pkg::APB_W'(r_num_workers);
        end
    end

    // ---------------- worker chain ----------------
    // Worker 0 always takes part, so a count of zero acts as one; counts above
    // the chain length simply enable every cell.
    assign w_carry[0] = '{vld: r_head_vld, have: 1'b0, load: '0, idx: '0};

    for (genvar g = 0; g < NW; g++) begin : g_cell
        assign w_active[g] = (g == 0) || (32'(g) < 32'(r_num_workers));

        llwa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (llwa_pkg::IDX_W'(g)),
            .i_active (w_active[g]),
            .i_carry  (w_carry[g]),
            .i_wr     (w_wr),
            .o_carry  (w_carry[g+1])
        );
    end

    // ---------------- control ----------------
    assign s_axis_tready = (r_state == llwa_pkg::S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_finish      = (r_state == llwa_pkg::S_DONE) && (!r_out_vld || m_axis_tready);

    // saturating add of the job size onto the winner's load
    assign w_sum      = {1'b0, r_best_load} + (llwa_pkg::LOAD_W+1)'(r_job_size);
    assign w_new_load = w_sum[llwa_pkg::LOAD_W] ? '1 : w_sum[llwa_pkg::LOAD_W-1:0];
    assign w_idx_ext  = {{llwa_pkg::WIDX_OUT_W{1'b0}}, r_best_idx};

    // start_batch clears at the accept edge, before the search begins
    assign w_wr.clr  = w_in_acc && s_axis_tuser;
    assign w_wr.en   = w_finish;
    assign w_wr.idx  = r_best_idx;
    assign w_wr.data = w_new_load;

    always_comb begin
        n_state     = r_state;
        n_job_id    = r_job_id;
        n_job_size  = r_job_size;
        n_head_vld  = 1'b0;
        n_best_idx  = r_best_idx;
        n_best_load = r_best_load;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            llwa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_job_id   = s_axis_tdata[llwa_pkg::JOB_W-1:0];
                    n_job_size = s_axis_tdata[2*llwa_pkg::JOB_W-1:llwa_pkg::JOB_W];
                    n_head_vld = 1'b1;
                    n_state    = llwa_pkg::S_SCAN;
                end
            end
            llwa_pkg::S_SCAN: begin
                if (w_carry[NW].vld) begin
                    n_best_idx  = w_carry[NW].idx;
                    n_best_load = w_carry[NW].load;
                    n_state     = llwa_pkg::S_DONE;
                end
            end
            llwa_pkg::S_DONE: begin
                if (w_finish) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {4'b0, w_new_load,
                                  w_idx_ext[llwa_pkg::WIDX_OUT_W-1:0], r_job_id};
                    n_state    = llwa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = llwa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= llwa_pkg::S_IDLE;
            r_head_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head_vld <= n_head_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_id    <= n_job_id;
        r_job_size  <= n_job_size;
        r_best_idx  <= n_best_idx;
        r_best_load <= n_best_load;
        r_out_data  <= n_out_data;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    // the search front only leaves the chain while a search is running
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_carry[NW].vld |-> (r_state == llwa_pkg::S_SCAN))
        else $error("search result outside scan");

    // an accepted item launches exactly one search front
    a_head_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_head_vld && (r_state == llwa_pkg::S_SCAN)))
        else $error("search not launched");

    // a delivered load is never below the size of the job just placed
    a_load_ge_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_out_data[51:20] >= llwa_pkg::LOAD_W'(r_job_size)))
        else $error("result load below job size");

endmodule
`default_nettype wire
